>>> src/mnoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnoc_pkg
// Shared codes, constants and types for the mixed numeric order compare.
// ----------------------------------------------------------------------------
package mnoc_pkg;

  localparam logic [7:0]  CODE_DOUBLE = 8'd1;
  localparam logic [7:0]  CODE_INT32  = 8'd16;
  localparam logic [7:0]  CODE_INT64  = 8'd18;

  localparam logic [63:0] SAFE_LIMIT  = 64'd9007199254740992;
  localparam int          MAG_W       = 54;
  localparam int          LZ_W        = 6;
  localparam logic [10:0] EXP_SAFE    = 11'd1076;
  localparam logic [10:0] EXP_ALL1    = 11'h7FF;

  localparam logic [1:0]  ORDER_LT    = 2'b11;
  localparam logic [1:0]  ORDER_EQ    = 2'b00;
  localparam logic [1:0]  ORDER_GT    = 2'b01;

  localparam int          IN_DATA_W   = 144;
  localparam int          OUT_DATA_W  = 8;

  typedef struct packed {
    logic [7:0]  typ;
    logic        safe;
    logic        nan;
    logic [63:0] key;
    logic [63:0] ikey;
  } conv_t;

endpackage

>>> src/mnoc_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnoc_conv
// Three-stage conversion of one typed value to an ordered 64-bit key.
// ----------------------------------------------------------------------------
module mnoc_conv (
  input  logic                 clk,
  input  logic                 en,
  input  logic [7:0]           type_i,
  input  logic [63:0]          bits_i,
  output mnoc_pkg::conv_t      res_o
);
  import mnoc_pkg::*;

  logic [63:0]      ival;
  logic [63:0]      mag64;
  logic             safe_nxt;
  logic [7:0]       typ1_r, typ2_r;
  logic [63:0]      bits1_r, bits2_r;
  logic             neg1_r, neg2_r, safe1_r, safe2_r;
  logic [MAG_W-1:0] mag1_r, mag2_r;
  logic [LZ_W-1:0]  lz_nxt, lz2_r;
  logic [MAG_W-1:0] norm;
  logic [63:0]      cvt, canon, fbits, fkey;
  logic             is_int2;
  conv_t            res_nxt, res_r;

  always_comb begin
    ival  = (type_i == CODE_INT32) ? {{32{bits_i[31]}}, bits_i[31:0]} : bits_i;
    mag64 = ival[63] ? (~ival + 64'd1) : ival;
    case (type_i)
      CODE_INT32:  safe_nxt = 1'b1;
      CODE_INT64:  safe_nxt = (mag64 <= SAFE_LIMIT);
      CODE_DOUBLE: safe_nxt = (bits_i[62:52] < EXP_SAFE) ||
                              (bits_i[62:52] == EXP_SAFE && bits_i[51:0] == '0);
      default:     safe_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      typ1_r  <= type_i;
      bits1_r <= ival;
      neg1_r  <= ival[63];
      mag1_r  <= mag64[MAG_W-1:0];
      safe1_r <= safe_nxt;
    end
  end

  always_comb begin
    lz_nxt = LZ_W'(MAG_W);
    for (int i = 0; i < MAG_W; i++) begin
      if (mag1_r[i]) lz_nxt = LZ_W'(MAG_W - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      typ2_r  <= typ1_r;
      bits2_r <= bits1_r;
      neg2_r  <= neg1_r;
      mag2_r  <= mag1_r;
      safe2_r <= safe1_r;
      lz2_r   <= lz_nxt;
    end
  end

  always_comb begin
    is_int2 = (typ2_r == CODE_INT32) || (typ2_r == CODE_INT64);
    norm    = mag2_r << lz2_r;
    if (mag2_r == '0) begin
      cvt = '0;
    end else begin
      cvt = {neg2_r, EXP_SAFE - 11'(lz2_r), norm[52:1]};
    end
    canon = (bits2_r[62:0] == '0) ? '0 : bits2_r;
    fbits = (is_int2 && safe2_r) ? cvt : canon;
    fkey  = fbits[63] ? ~fbits : {1'b1, fbits[62:0]};
    res_nxt.typ  = typ2_r;
    res_nxt.safe = safe2_r;
    res_nxt.nan  = (typ2_r == CODE_DOUBLE) && (bits2_r[62:52] == EXP_ALL1) &&
                   (bits2_r[51:0] != '0);
    res_nxt.key  = (is_int2 && !safe2_r) ? {~bits2_r[63], bits2_r[62:0]} : fkey;
    res_nxt.ikey = {~bits2_r[63], bits2_r[62:0]};
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

>>> src/mixed_numeric_order_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_numeric_order_compare
// Orders two typed numeric values (double, int32, int64) as -1, 0 or 1.
// Pipeline: three conversion stages, then the compare stage that feeds the
// output register. Throughput: one beat per cycle while no stall holds the pipeline.
// A stall on the output holds the whole pipeline in place.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module mixed_numeric_order_compare (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // type_first[7:0], bits_first[71:8], type_second[79:72], bits_second[143:80]
  input  logic [mnoc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // order[1:0], zero fill above
  output logic [mnoc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mnoc_pkg::*;

  logic        en;
  logic [2:0]  vld_r;
  logic        out_valid_r;
  logic [1:0]  order_r, order_nxt;
  conv_t       ca, cb;
  logic        same;
  logic        ints;
  logic [63:0] ka, kb;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  mnoc_conv u_conv_a (
    .clk    (clk),
    .en     (en),
    .type_i (in_tdata[7:0]),
    .bits_i (in_tdata[71:8]),
    .res_o  (ca)
  );

  mnoc_conv u_conv_b (
    .clk    (clk),
    .en     (en),
    .type_i (in_tdata[79:72]),
    .bits_i (in_tdata[143:80]),
    .res_o  (cb)
  );

  always_comb begin
    same = (ca.typ == cb.typ);
    ints = (ca.typ == CODE_INT32 || ca.typ == CODE_INT64) &&
           (cb.typ == CODE_INT32 || cb.typ == CODE_INT64);
    ka   = ints ? ca.ikey : ca.key;
    kb   = ints ? cb.ikey : cb.key;
    if ((ca.safe && cb.safe) || same) begin
      if (same && ca.typ == CODE_DOUBLE && (ca.nan || cb.nan)) begin
        order_nxt = (ca.nan && cb.nan) ? ORDER_EQ : (ca.nan ? ORDER_LT : ORDER_GT);
      end else if (ca.safe && cb.safe || ca.typ == CODE_DOUBLE ||
                   ca.typ == CODE_INT32 || ca.typ == CODE_INT64) begin
        order_nxt = (ka < kb) ? ORDER_LT : ((ka > kb) ? ORDER_GT : ORDER_EQ);
      end else begin
        order_nxt = ORDER_EQ;
      end
    end else begin
      order_nxt = (ca.typ < cb.typ) ? ORDER_LT : ORDER_GT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[1:0], in_tvalid};
      out_valid_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) order_r <= order_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2){1'b0}}, order_r};

endmodule

>>> src/mnoc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnoc_checker
// Port-level checks for the mixed numeric order compare.
// ----------------------------------------------------------------------------
module mnoc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [mnoc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mnoc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mnoc_pkg::*;

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed under stall");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b10)
    else $error("order code out of range");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:2] == '0)
    else $error("nonzero fill in output beat");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output drain");

endmodule

bind mixed_numeric_order_compare mnoc_checker u_mnoc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/tb_mixed_numeric_order_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mixed_numeric_order_compare
// Drives typed value pairs into the mixed numeric order compare and checks
// every order beat against a local predictor of the safe numeric compare
// and the type-code fallback, under random idling and output back-pressure.
// ----------------------------------------------------------------------------
module tb_mixed_numeric_order_compare;
  import mnoc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [1:0] order_q[$];
  int         mismatches;
  longint     cycles;
  bit         sender_idle_on;
  bit         receiver_idle_on;
  int         hold_off;

  mixed_numeric_order_compare dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_nan64(logic [63:0] b);
    return b[62:52] == EXP_ALL1 && b[51:0] != 52'd0;
  endfunction

  function automatic bit safe_value(logic [7:0] t, logic [63:0] b);
    longint v;
    real    d;
    v = b;
    if (t == CODE_INT32) return 1'b1;
    if (t == CODE_INT64) return v >= -longint'(SAFE_LIMIT) && v <= longint'(SAFE_LIMIT);
    if (t == CODE_DOUBLE) begin
      if (is_nan64(b)) return 1'b0;
      d = $bitstoreal(b);
      return d >= -9007199254740992.0 && d <= 9007199254740992.0;
    end
    return 1'b0;
  endfunction

  function automatic real real_value(logic [7:0] t, logic [63:0] b);
    int     w;
    longint v;
    w = b[31:0];
    v = b;
    if (t == CODE_INT32) return real'(w);
    if (t == CODE_INT64) return real'(v);
    return $bitstoreal(b);
  endfunction

  function automatic logic [1:0] order_of(int c);
    return c < 0 ? ORDER_LT : (c > 0 ? ORDER_GT : ORDER_EQ);
  endfunction

  function automatic logic [1:0] predict_order(logic [7:0] ta, logic [63:0] ba,
                                               logic [7:0] tb, logic [63:0] bb);
    real    x, y;
    int     wa, wb;
    longint la, lb;
    bit     na, nb;
    wa = ba[31:0];
    wb = bb[31:0];
    la = ba;
    lb = bb;
    na = is_nan64(ba);
    nb = is_nan64(bb);
    if (safe_value(ta, ba) && safe_value(tb, bb)) begin
      x = real_value(ta, ba);
      y = real_value(tb, bb);
      return order_of(x < y ? -1 : (x > y ? 1 : 0));
    end
    if (ta != tb) return ta < tb ? ORDER_LT : ORDER_GT;
    if (ta == CODE_INT32) return order_of(wa < wb ? -1 : (wa > wb ? 1 : 0));
    if (ta == CODE_INT64) return order_of(la < lb ? -1 : (la > lb ? 1 : 0));
    if (ta == CODE_DOUBLE) begin
      if (na && nb) return ORDER_EQ;
      if (na) return ORDER_LT;
      if (nb) return ORDER_GT;
      x = $bitstoreal(ba);
      y = $bitstoreal(bb);
      return order_of(x < y ? -1 : (x > y ? 1 : 0));
    end
    return ORDER_EQ;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_pair(logic [7:0] ta, logic [63:0] ba, logic [7:0] tb, logic [63:0] bb);
    int gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bb, tb, ba, ta};
    do @(posedge clk); while (!in_tready);
    order_q.push_back(predict_order(ta, ba, tb, bb));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls plus a long hold-off on request
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        hold_off--;
      end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (order_q.size() == 0) begin
        report_mismatch("order beat with nothing expected");
      end else begin
        want = order_q.pop_front();
        if (out_tdata[1:0] !== want)
          report_mismatch($sformatf("order got %b want %b", out_tdata[1:0], want));
        if (out_tdata[7:2] !== 6'd0)
          report_mismatch($sformatf("fill bits %b", out_tdata[7:2]));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("mixed_numeric_order_compare verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_type();
    case ($urandom_range(0, 9))
      0, 1, 2: return CODE_DOUBLE;
      3, 4, 5: return CODE_INT32;
      6, 7, 8: return CODE_INT64;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_bits(logic [7:0] t);
    logic [63:0] r;
    longint      s;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return r;
      1: begin
        s = longint'($urandom_range(0, 2000)) - 1000;
        return t == CODE_DOUBLE ? $realtobits(real'(s) / 4.0) : 64'(s);
      end
      2: begin
        s = longint'(SAFE_LIMIT) + $urandom_range(0, 4) - 2;
        if (r[0]) s = -s;
        return t == CODE_DOUBLE ? $realtobits(real'(s)) : 64'(s);
      end
      3: return {r[63], EXP_ALL1, ($urandom_range(0, 1) ? 52'd0 : r[51:0])};
      4: return {r[63], 11'($urandom_range(1020, 1090)), r[51:0]};
      default: return {r[63:32], 32'($urandom_range(0, 7)) - 32'd3};
    endcase
  endfunction

  task automatic test_directed();
    logic [63:0] dnan, dinf, dninf, dpz, dnz, dlim, dmax;
    dnan  = {1'b0, EXP_ALL1, 52'h8000000000000};
    dinf  = {1'b0, EXP_ALL1, 52'd0};
    dninf = {1'b1, EXP_ALL1, 52'd0};
    dpz   = 64'd0;
    dnz   = {1'b1, 63'd0};
    dlim  = $realtobits(9007199254740992.0);
    dmax  = 64'hFFFF_FFFF_FFFF_FFFF;
    send_pair(CODE_DOUBLE, dpz, CODE_DOUBLE, dnz);
    send_pair(CODE_DOUBLE, dnz, CODE_INT32, 64'd0);
    send_pair(CODE_INT32, 64'hFFFF_FFFF_0000_0005, CODE_INT32, 64'h5);
    send_pair(CODE_INT32, 64'h8000_0000, CODE_INT32, 64'h7FFF_FFFF);
    send_pair(CODE_INT64, SAFE_LIMIT, CODE_DOUBLE, dlim);
    send_pair(CODE_INT64, SAFE_LIMIT + 1, CODE_DOUBLE, dlim);
    send_pair(CODE_INT64, -SAFE_LIMIT, CODE_INT32, 64'hFFFF_FFFF);
    send_pair(CODE_INT64, 64'h8000_0000_0000_0000, CODE_INT64, 64'h7FFF_FFFF_FFFF_FFFF);
    send_pair(CODE_DOUBLE, dnan, CODE_DOUBLE, dninf);
    send_pair(CODE_DOUBLE, dnan, CODE_DOUBLE, dmax);
    send_pair(CODE_DOUBLE, dinf, CODE_INT32, 64'd1);
    send_pair(CODE_DOUBLE, dninf, CODE_DOUBLE, dinf);
    send_pair(CODE_DOUBLE, dinf, CODE_DOUBLE, dinf);
    send_pair(CODE_DOUBLE, dnan, CODE_INT64, 64'd3);
    send_pair(8'd0, dmax, 8'd255, 64'd0);
    send_pair(8'd7, 64'd1, 8'd7, 64'd2);
    send_pair(8'd255, dmax, CODE_INT32, 64'd0);
    send_pair(CODE_INT32, 64'd1, CODE_DOUBLE, $realtobits(1.5));
    send_pair(CODE_DOUBLE, $realtobits(-2.5), CODE_INT64, dmax);
    send_pair(CODE_INT64, 64'd12, CODE_INT64, 64'd12);
  endtask

  task automatic test_back_pressure();
    int n;
    hold_off = 200;
    for (n = 0; n < 40; n++)
      send_pair(rand_type(), rand_bits(CODE_INT64), rand_type(), rand_bits(CODE_DOUBLE));
  endtask

  task automatic test_random(int count);
    int n;
    logic [7:0] ta, tb;
    for (n = 0; n < count; n++) begin
      ta = rand_type();
      tb = $urandom_range(0, 1) ? ta : rand_type();
      send_pair(ta, rand_bits(ta), tb, rand_bits(tb));
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    mismatches       = 0;
    cycles           = 0;
    hold_off         = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_pressure();
    test_random(700);
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    test_random(200);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("mixed_numeric_order_compare verification clean");
    end else begin
      $display("mixed_numeric_order_compare verification failed");
    end
    $finish;
  end

endmodule
